FILE: sv/hcrc8_pkg.sv
// shared constants and the crc-8 byte update for the header-synced command receiver
// no dependencies; used by header_crc8_command_packet_receiver
package hcrc8_pkg;

  localparam int DATA_BYTES = 6;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [7:0] HDR_FIRST_RST  = 8'd170;
  localparam logic [7:0] HDR_SECOND_RST = 8'd85;
  localparam logic [7:0] LOW_LIMIT_RST  = 8'd100;
  localparam logic [7:0] HIGH_LIMIT_RST = 8'd200;
  localparam logic [7:0] CMD_RST        = 8'd150;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 3'd3;

  // result tdata: mask, six motors, three counters, padded to bytes
  localparam int MASK_W     = DATA_BYTES;
  localparam int OUT_BITS   = MASK_W + 8 * DATA_BYTES + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // crc-8, msb first, one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'd0) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: sv/header_crc8_command_packet_receiver.sv
// a result appears on out_* in the cycle after the crc byte is accepted
// throughput: one byte per cycle; input stalls only when a result is still waiting
//   on out_tready and the byte in front is the crc byte of the next packet
// reset (rst_n low, synchronous): hunting, crc and index zero, registers to defaults,
//   held commands 150, counters zero, no result pending
module header_crc8_command_packet_receiver (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input request
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [7:0]                               in_tdata,   // [7:0] data_byte
  input  logic                                     in_tuser,   // [0] op (1 = line error)
  // result request
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // [5:0] range_error_mask, [13:6] motor_0 .. [53:46] motor_5,
  // [85:54] good_packets, [117:86] crc_errors, [149:118] range_errors, rest zero
  output logic [hcrc8_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tuser,  // [0] crc_bad
  // configuration writes
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [hcrc8_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [7:0]                               cfg_data
);

  typedef enum logic [1:0] {PH_HUNT, PH_GOT_FIRST, PH_DATA, PH_CHECK} phase_t;

  localparam int NB = hcrc8_pkg::DATA_BYTES;
  localparam int CW = hcrc8_pkg::CNT_W;
  localparam int PAD_W = hcrc8_pkg::OUT_TDATA_W - hcrc8_pkg::OUT_BITS;

  logic [7:0] hdr_first_r, hdr_second_r, low_limit_r, high_limit_r;

  phase_t                        phase_r, phase_nxt;
  logic [hcrc8_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic [7:0]                    pend_r [NB];
  logic [7:0]                    held_r [NB];
  logic [7:0]                    held_nxt [NB];
  logic [CW-1:0]                 good_r, good_nxt;
  logic [CW-1:0]                 crcerr_r, crcerr_nxt;
  logic [CW-1:0]                 rangeerr_r, rangeerr_nxt;

  logic                          out_valid_r;
  logic [hcrc8_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                          out_bad_r;

  logic                          in_fire, pend_we, emit, bad;
  logic [hcrc8_pkg::MASK_W-1:0]  mask;
  logic [2:0]                    n_range;
  logic [7:0]                    b;

  assign b         = in_tdata;
  assign cfg_ready = 1'b1;
  assign in_tready = out_tready || !out_valid_r || (phase_r != PH_CHECK);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    good_nxt     = good_r;
    crcerr_nxt   = crcerr_r;
    rangeerr_nxt = rangeerr_r;
    held_nxt     = held_r;
    pend_we      = 1'b0;
    emit         = 1'b0;
    bad          = 1'b0;
    mask         = '0;
    n_range      = '0;
    if (in_fire) begin
      if (in_tuser) begin
        // line error: abandon packet, clear good and crc counters
        phase_nxt  = PH_HUNT;
        idx_nxt    = '0;
        crc_nxt    = '0;
        good_nxt   = '0;
        crcerr_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_HUNT: begin
            if (b == hdr_first_r) phase_nxt = PH_GOT_FIRST;
          end
          PH_GOT_FIRST: begin
            if (b == hdr_second_r) begin
              phase_nxt = PH_DATA;
              idx_nxt   = '0;
              crc_nxt   = '0;
            end else if (b != hdr_first_r) begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_DATA: begin
            pend_we = 1'b1;
            crc_nxt = hcrc8_pkg::crc8_byte(crc_r, b);
            idx_nxt = idx_r + hcrc8_pkg::IDX_W'(1);
            if (idx_r == hcrc8_pkg::IDX_W'(NB - 1)) phase_nxt = PH_CHECK;
          end
          PH_CHECK: begin
            emit      = 1'b1;
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            crc_nxt   = '0;
            if (b != crc_r) begin
              bad        = 1'b1;
              crcerr_nxt = crcerr_r + CW'(1);
            end else begin
              for (int i = 0; i < NB; i++) begin
                if (pend_r[i] >= low_limit_r && pend_r[i] <= high_limit_r) begin
                  held_nxt[i] = pend_r[i];
                end else begin
                  mask[i] = 1'b1;
                end
              end
              for (int i = 0; i < NB; i++) begin
                n_range = n_range + 3'(mask[i]);
              end
              good_nxt     = good_r + CW'(1);
              rangeerr_nxt = rangeerr_r + CW'(n_range);
            end
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[hcrc8_pkg::MASK_W-1:0] = mask;
    for (int i = 0; i < NB; i++) begin
      out_data_nxt[hcrc8_pkg::MASK_W + 8*i +: 8] = held_nxt[i];
    end
    out_data_nxt[hcrc8_pkg::MASK_W + 8*NB +: CW]        = good_nxt;
    out_data_nxt[hcrc8_pkg::MASK_W + 8*NB + CW +: CW]   = crcerr_nxt;
    out_data_nxt[hcrc8_pkg::MASK_W + 8*NB + 2*CW +: CW] = rangeerr_nxt;
    if (PAD_W > 0) out_data_nxt[hcrc8_pkg::OUT_TDATA_W-1 -: PAD_W] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= hcrc8_pkg::HDR_FIRST_RST;
      hdr_second_r <= hcrc8_pkg::HDR_SECOND_RST;
      low_limit_r  <= hcrc8_pkg::LOW_LIMIT_RST;
      high_limit_r <= hcrc8_pkg::HIGH_LIMIT_RST;
      phase_r      <= PH_HUNT;
      idx_r        <= '0;
      crc_r        <= '0;
      good_r       <= '0;
      crcerr_r     <= '0;
      rangeerr_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NB; i++) held_r[i] <= hcrc8_pkg::CMD_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hcrc8_pkg::CFG_HEADER_FIRST:  hdr_first_r  <= cfg_data;
          hcrc8_pkg::CFG_HEADER_SECOND: hdr_second_r <= cfg_data;
          hcrc8_pkg::CFG_LOW_LIMIT:     low_limit_r  <= cfg_data;
          hcrc8_pkg::CFG_HIGH_LIMIT:    high_limit_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      crc_r      <= crc_nxt;
      good_r     <= good_nxt;
      crcerr_r   <= crcerr_nxt;
      rangeerr_r <= rangeerr_nxt;
      held_r     <= held_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    // payload registers, no reset
    if (pend_we) pend_r[idx_r] <= b;
    if (emit) begin
      out_data_r <= out_data_nxt;
      out_bad_r  <= bad;
    end
  end

  // crc byte of a packet always yields a result next cycle
  a_check_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser && phase_r == PH_CHECK |=> out_tvalid)
    else $error("crc byte accepted without a result");

  // the byte index stays inside the data window while collecting
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> idx_r < hcrc8_pkg::IDX_W'(NB))
    else $error("byte index out of data window");

  // a dropped packet reports no range errors
  a_bad_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[hcrc8_pkg::MASK_W-1:0] == '0)
    else $error("crc_bad result carries a range mask");

  // input stalls only for a crc byte behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && phase_r == PH_CHECK)
    else $error("input stalled without a waiting result");

endmodule
